FILE: hdl/strict_priority_multi_queue_defines.svh
// Assertion macros used by the bound checker file (spmq_checker.sv).
`ifndef STRICT_PRIORITY_MULTI_QUEUE_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPMQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spmq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPMQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spmq: next-cycle check failed");

`endif

FILE: hdl/spmq_pkg.sv
package spmq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int LEVELS_DEF      = 3;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic       action;
        logic [1:0] priority_req;
        logic [7:0] item;
    } req_t;

    typedef struct packed {
        logic [7:0] out_item;
        logic [1:0] out_priority;
        logic [1:0] status;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIN  = 3'b100
    } state_t;

endpackage

FILE: hdl/spmq_ctrl.sv
module spmq_ctrl import spmq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign cmd.capture  = s_valid && s_ready;
    assign cmd.exec     = (state_reg == S_EXEC);
    assign cmd.load_out = (state_reg == S_FIN) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: hdl/spmq_datapath.sv
module spmq_datapath import spmq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int LEVELS      = LEVELS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  cmd_t cmd,
    input  req_t s_data,
    output rsp_t m_data
);

    localparam int IDXW      = $clog2(QUEUE_DEPTH);
    localparam int CNTW      = $clog2(QUEUE_DEPTH + 1);
    localparam int LVW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ADDRW     = LVW + IDXW;
    localparam int MEM_DEPTH = LEVELS * (2 ** IDXW);

    req_t            req_reg;
    logic [IDXW-1:0] head_reg [LEVELS];
    logic [IDXW-1:0] tail_reg [LEVELS];
    logic [CNTW-1:0] count_reg [LEVELS];
    logic [7:0]      mem [MEM_DEPTH];
    logic [7:0]      rd_data_reg;
    logic [1:0]      res_status_reg;
    logic [1:0]      res_level_reg;
    logic            res_hit_reg;
    rsp_t            out_reg;

    logic [3:0]      req_ext;
    logic            lvl_ok;
    logic [LVW-1:0]  enq_q;
    logic            enq_full;
    logic [LVW-1:0]  deq_q;
    logic            deq_hit;
    logic            enq_do;
    logic            deq_do;
    logic [1:0]      status_c;
    logic [IDXW-1:0] tail_sel;
    logic [IDXW-1:0] head_sel;

    assign req_ext  = {2'b00, req_reg.priority_req};
    assign lvl_ok   = (req_ext != 4'd0) && (req_ext <= 4'(LEVELS));
    assign enq_q    = LVW'(req_ext - 4'd1);
    assign enq_full = lvl_ok && (count_reg[enq_q] == CNTW'(QUEUE_DEPTH));
    assign tail_sel = tail_reg[enq_q];
    assign head_sel = head_reg[deq_q];

    // level 1 (index 0) wins: scan down so the lowest non-empty index stays
    always_comb begin
        deq_q   = '0;
        deq_hit = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (count_reg[i] != '0) begin
                deq_q   = LVW'(i);
                deq_hit = 1'b1;
            end
        end
    end

    assign enq_do = cmd.exec && (req_reg.action == ACT_ENQ) && lvl_ok && !enq_full;
    assign deq_do = cmd.exec && (req_reg.action == ACT_DEQ) && deq_hit;

    always_comb begin
        if (req_reg.action == ACT_ENQ) begin
            status_c = (lvl_ok && !enq_full) ? ST_OK : ST_FULL;
        end else begin
            status_c = deq_hit ? ST_OK : ST_EMPTY;
        end
    end

    function automatic logic [IDXW-1:0] wrap_inc(input logic [IDXW-1:0] idx);
        return (idx == IDXW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (enq_do) begin
            mem[ADDRW'({enq_q, tail_sel})] <= req_reg.item;
        end
        if (deq_do) begin
            rd_data_reg <= mem[ADDRW'({deq_q, head_sel})];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < LEVELS; i++) begin
                if (enq_do && (enq_q == LVW'(i))) begin
                    tail_reg[i]  <= wrap_inc(tail_reg[i]);
                    count_reg[i] <= count_reg[i] + 1'b1;
                end
                if (deq_do && (deq_q == LVW'(i))) begin
                    head_reg[i]  <= wrap_inc(head_reg[i]);
                    count_reg[i] <= count_reg[i] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_status_reg <= status_c;
            res_hit_reg    <= deq_do;
            res_level_reg  <= deq_do ? 2'(int'(deq_q) + 1) : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.out_item     <= res_hit_reg ? rd_data_reg : 8'd0;
            out_reg.out_priority <= res_level_reg;
            out_reg.status       <= res_status_reg;
        end
    end

    assign m_data = out_reg;

endmodule

FILE: hdl/strict_priority_multi_queue.sv
// Channel   Ports                       Payload  Role
// request   s_valid s_ready s_data      req_t    enqueue or dequeue command
// result    m_valid m_ready m_data      rsp_t    byte, level served, status
//
// Each request passes through three steps: capture, execute (FIFO push, or pop with
// a registered read of the shared byte memory), then load into the output register.
// A new request is accepted while the previous result still waits on m_ready.
// Reset clears head, tail and fill count of every level; no memory clearing pass.
// A stalled result holds the block in its final step until m_ready is seen.
module strict_priority_multi_queue import spmq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int LEVELS      = LEVELS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    cmd_t cmd;

    spmq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    spmq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LEVELS      (LEVELS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

FILE: hdl/spmq_checker.sv
`include "strict_priority_multi_queue_defines.svh"

module spmq_checker import spmq_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input req_t s_data,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    logic rsp_failed;
    logic rsp_blank;

    assign rsp_failed = m_valid && (m_data.status != ST_OK);
    assign rsp_blank  = (m_data.out_item == 8'd0) && (m_data.out_priority == 2'd0);

    `SPMQ_ASSERT_NEXT(a_m_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `SPMQ_ASSERT_NEXT(a_m_data_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_data))
    `SPMQ_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SPMQ_ASSERT_IMPL(a_fail_zero, aclk, aresetn, rsp_failed, rsp_blank)
    `SPMQ_ASSERT_IMPL(a_result_caused, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready, 3))

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (.*);

FILE: verif/strict_priority_multi_queue_checker.sv
`timescale 1ns / 100ps

module strict_priority_multi_queue_checker import spmq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int LEVELS      = LEVELS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  req_t s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  rsp_t m_data,
    output int   error_count,
    output int   pending_count,
    output int   served_count,
    output int   full_count,
    output int   empty_count
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]       level_mem [LEVELS][QUEUE_DEPTH];
    logic [IDX_W-1:0] rd_ptr    [LEVELS];
    logic [IDX_W-1:0] wr_ptr    [LEVELS];
    logic [CNT_W-1:0] occupancy [LEVELS];
    rsp_t             awaited_rsp [$];

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Apply one request to the shadow queues and work out its result.
    task automatic serve_request(input req_t req, output rsp_t rsp);
        int  lvl;
        bit  found;
        rsp.out_item     = 8'd0;
        rsp.out_priority = 2'd0;
        rsp.status       = ST_OK;
        found            = 1'b0;
        if (req.action == ACT_ENQ) begin
            if (req.priority_req == 2'd0 || int'(req.priority_req) > LEVELS) begin
                // no such level: drop the byte
                rsp.status = ST_FULL;
            end else begin
                lvl = int'(req.priority_req) - 1;
                if (occupancy[lvl] == CNT_W'(QUEUE_DEPTH)) begin
                    rsp.status = ST_FULL;
                end else begin
                    level_mem[lvl][wr_ptr[lvl]] = req.item;
                    wr_ptr[lvl]    = next_slot(wr_ptr[lvl]);
                    occupancy[lvl] = occupancy[lvl] + 1'b1;
                end
            end
        end else begin
            // level 1 first
            for (int q = 0; q < LEVELS; q++) begin
                if (!found && occupancy[q] != '0) begin
                    rsp.out_item     = level_mem[q][rd_ptr[q]];
                    rsp.out_priority = 2'(q + 1);
                    rd_ptr[q]        = next_slot(rd_ptr[q]);
                    occupancy[q]     = occupancy[q] - 1'b1;
                    found            = 1'b1;
                end
            end
            if (!found) begin
                rsp.status = ST_EMPTY;
            end
        end
    endtask

    always @(posedge aclk) begin
        rsp_t predicted;
        if (!aresetn) begin
            for (int q = 0; q < LEVELS; q++) begin
                rd_ptr[q]    = '0;
                wr_ptr[q]    = '0;
                occupancy[q] = '0;
            end
            awaited_rsp.delete();
            error_count  = 0;
            served_count = 0;
            full_count   = 0;
            empty_count  = 0;
        end else begin
            if (s_valid && s_ready) begin
                serve_request(s_data, predicted);
                awaited_rsp.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (awaited_rsp.size() == 0) begin
                    $display("%0t: result with no request outstanding: expected none, actual %p",
                             $time, m_data);
                    error_count++;
                end else begin
                    predicted = awaited_rsp.pop_front();
                    if (m_data.out_item !== predicted.out_item) begin
                        $display("%0t: out_item mismatch: expected %0d, actual %0d",
                                 $time, predicted.out_item, m_data.out_item);
                        error_count++;
                    end
                    if (m_data.out_priority !== predicted.out_priority) begin
                        $display("%0t: out_priority mismatch: expected %0d, actual %0d",
                                 $time, predicted.out_priority, m_data.out_priority);
                        error_count++;
                    end
                    if (m_data.status !== predicted.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, predicted.status, m_data.status);
                        error_count++;
                    end
                    case (predicted.status)
                        ST_FULL:  full_count++;
                        ST_EMPTY: empty_count++;
                        default: begin
                            if (predicted.out_priority != 2'd0) begin
                                served_count++;
                            end
                        end
                    endcase
                end
            end
        end
        pending_count = awaited_rsp.size();
    end

endmodule

FILE: verif/strict_priority_multi_queue_tb.sv
`timescale 1ns / 100ps

module strict_priority_multi_queue_tb;
    import spmq_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 1850;
    localparam int HOLD_CYCLES  = 400;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    int error_count;
    int pending_count;
    int served_count;
    int full_count;
    int empty_count;
    int burst_left = 0;
    int sent_count = 0;

    always begin
        aclk = 1'b0;
        #(CLK_PERIOD / 2);
        aclk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    strict_priority_multi_queue i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    strict_priority_multi_queue_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .error_count   (error_count),
        .pending_count (pending_count),
        .served_count  (served_count),
        .full_count    (full_count),
        .empty_count   (empty_count)
    );

    function automatic req_t make_req(input logic act, input logic [1:0] lvl,
                                      input logic [7:0] byte_val);
        req_t r;
        r.action       = act;
        r.priority_req = lvl;
        r.item         = byte_val;
        return r;
    endfunction

    // Offer one request in bursts; idle for a random gap once a burst runs out.
    task automatic send_request(input req_t req);
        int gap;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // Result side: the stall pattern switches among four random modes, with two long hold-offs.
    initial begin : result_sink
        int cycle_count = 0;
        int mode        = 0;
        int hold_left   = 0;
        int run_left    = 0;
        bit run_state   = 1'b0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count == 1500 || cycle_count == 6000) begin
                hold_left = HOLD_CYCLES;
            end
            if (cycle_count % 300 == 0) begin
                mode = $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 9) != 0);
                    default: begin
                        if (run_left == 0) begin
                            run_state = !run_state;
                            run_left  = $urandom_range(1, 12);
                        end
                        run_left--;
                        m_ready <= run_state;
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        int         enq_mix [5] = '{90, 50, 15, 70, 35};
        int         phase_idx   = 0;
        int         phase_len;
        int         enq_pct;
        int         rnd_sent    = 0;
        req_t       req;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty, missing level, byte extremes, priority order
        send_request(make_req(ACT_DEQ, 2'd0, 8'h00));
        send_request(make_req(ACT_ENQ, 2'd0, 8'h5A));
        send_request(make_req(ACT_ENQ, 2'd3, 8'hFF));
        send_request(make_req(ACT_ENQ, 2'd2, 8'h00));
        send_request(make_req(ACT_ENQ, 2'd1, 8'h81));
        send_request(make_req(ACT_DEQ, 2'd3, 8'hFF));
        send_request(make_req(ACT_DEQ, 2'd1, 8'h00));
        send_request(make_req(ACT_ENQ, 2'd1, 8'h7E));
        send_request(make_req(ACT_ENQ, 2'd3, 8'h01));
        send_request(make_req(ACT_DEQ, 2'd2, 8'h55));
        send_request(make_req(ACT_DEQ, 2'd0, 8'hAA));
        send_request(make_req(ACT_DEQ, 2'd1, 8'h00));
        send_request(make_req(ACT_DEQ, 2'd3, 8'hFF));

        // random phases swing between filling and draining the queues
        while (rnd_sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(40, 200);
            if (phase_len > RANDOM_ITEMS - rnd_sent) begin
                phase_len = RANDOM_ITEMS - rnd_sent;
            end
            enq_pct   = enq_mix[phase_idx % 5];
            phase_idx++;
            repeat (phase_len) begin
                req.action       = ($urandom_range(1, 100) <= enq_pct) ? ACT_ENQ : ACT_DEQ;
                req.priority_req = ($urandom_range(0, 19) == 0) ? 2'd0
                                                                : 2'($urandom_range(1, 3));
                case ($urandom_range(0, 9))
                    0:       req.item = 8'h00;
                    1:       req.item = 8'hFF;
                    default: req.item = 8'($urandom);
                endcase
                send_request(req);
                rnd_sent++;
            end
        end
        s_valid <= 1'b0;

        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (10) @(posedge aclk);

        $display("run covered %0d requests: %0d bytes dequeued, %0d enqueues rejected,",
                 sent_count, served_count, full_count);
        $display("%0d dequeues on empty queues, two result hold-offs of %0d cycles each",
                 empty_count, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("strict_priority_multi_queue_tb: clean");
        end else begin
            $display("strict_priority_multi_queue_tb: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * 400000);
        $display("strict_priority_multi_queue_tb: errors");
        $finish;
    end

endmodule

FILE: strict_priority_multi_queue.f
+incdir+hdl
hdl/spmq_pkg.sv
hdl/spmq_ctrl.sv
hdl/spmq_datapath.sv
hdl/strict_priority_multi_queue.sv
hdl/spmq_checker.sv
verif/strict_priority_multi_queue_checker.sv
verif/strict_priority_multi_queue_tb.sv
